FILE: rtl/chm_pkg.sv
// Shared types and codes for the chained hash map engine.
// No dependencies; used by every rtl file.
package chm_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_value;
        logic [8:0]  live_entries;
    } rsp_t;

    localparam logic [1:0] MODE_PUT = 2'd0;
    localparam logic [1:0] MODE_GET = 2'd1;
    localparam logic [1:0] MODE_DEL = 2'd2;
    localparam logic [1:0] MODE_NOP = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_MISSING  = 3'd3;
    localparam logic [2:0] ST_DELETED  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    typedef struct packed {
        logic load;       // capture request, start modulo
        logic mod_step;   // one restoring-division step
        logic head_rd;    // read bucket head
        logic ent_rd;     // read entry at cur
        logic advance;    // cur <= next, prev <= cur
        logic scan_step;  // free-slot scan advance
        logic do_update;
        logic do_insert;
        logic do_delete;
        logic set_rsp;
        logic [2:0] rsp_status;
    } cmd_t;

    typedef struct packed {
        logic mod_done;
        logic cur_nil;
        logic key_match;
        logic walk_limit;
        logic scan_done;
        logic scan_found;
        logic [1:0] mode;
    } sts_t;

endpackage

FILE: rtl/chained_hash_map_engine.sv
// Top level of the chained hash map engine: register, controller, datapath.
// Depends on chm_pkg, chm_ctrl, chm_datapath.
// One request at a time: a bit-serial modulo of the 32-bit key, a bucket head
// read, a test and a compare per chain entry visited, a test to find the end
// of a chain that holds no match, and on an insert a scan of the pool for the
// lowest free slot, then a result state and a return to idle to take the next
// request. An unused mode skips the walk.
// No clearing pass after reset.
module chained_hash_map_engine #(
    parameter int NUM_BUCKETS = 256,
    parameter int NUM_ENTRIES = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  chm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output chm_pkg::rsp_t rsp,
    input  logic          cfg_we,
    input  logic [8:0]    cfg_data
);
    logic [8:0] bucket_count_reg;
    chm_pkg::cmd_t cmd;
    chm_pkg::sts_t sts;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            bucket_count_reg <= 9'd256;
        else if (cfg_we)
            bucket_count_reg <= cfg_data;
    end

    chm_ctrl u_ctrl (
        .clk, .rst_n, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
        .sts, .cmd
    );

    chm_datapath #(.NUM_BUCKETS(NUM_BUCKETS), .NUM_ENTRIES(NUM_ENTRIES)) u_dp (
        .clk, .rst_n, .req, .bucket_count(bucket_count_reg), .cmd, .sts, .rsp
    );
endmodule

FILE: rtl/chm_datapath.sv
// Datapath: modulo unit, head/entry memories, chain walk and free scan.
// Depends on chm_pkg.
module chm_datapath #(
    parameter int NUM_BUCKETS = 256,
    parameter int NUM_ENTRIES = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  chm_pkg::req_t   req,
    input  logic [8:0]      bucket_count,
    input  chm_pkg::cmd_t   cmd,
    output chm_pkg::sts_t   sts,
    output chm_pkg::rsp_t   rsp
);
    localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int PW = $clog2(NUM_ENTRIES + 1);
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int DW = $clog2(NUM_BUCKETS + 1);
    localparam logic [PW-1:0] NIL = PW'(NUM_ENTRIES);

    logic [PW-1:0] head_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] head_valid_reg;
    logic [31:0]   key_mem  [NUM_ENTRIES];
    logic [31:0]   val_mem  [NUM_ENTRIES];
    logic [PW-1:0] next_mem [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] in_use_reg;

    logic [1:0]  mode_reg;
    logic [31:0] key_reg, val_reg;
    logic [DW-1:0] div_reg;
    logic [31:0] quo_reg;
    logic [DW:0] rem_reg;
    logic [5:0]  mcnt_reg;
    logic [PW-1:0] cur_reg, prev_reg, headv_reg;
    logic [31:0] ekey_reg, evalue_reg;
    logic [PW-1:0] enext_reg;
    logic [PW:0] steps_reg;
    logic [PW-1:0] scan_reg;
    logic [PW-1:0] total_reg;
    chm_pkg::rsp_t rsp_reg;

    logic [BW-1:0] bucket;
    logic [DW:0]   trial;
    logic [DW-1:0] div_next;

    assign bucket = BW'(rem_reg);
    assign trial  = {rem_reg[DW-1:0], quo_reg[31]};
    assign div_next = (bucket_count == 9'd0 || 32'(bucket_count) > NUM_BUCKETS)
                      ? DW'(NUM_BUCKETS) : DW'(bucket_count);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            head_valid_reg <= '0;
            in_use_reg     <= '0;
            total_reg      <= '0;
        end
        else begin
            if (cmd.do_insert) begin
                head_valid_reg[bucket]    <= 1'b1;
                in_use_reg[EW'(scan_reg)] <= 1'b1;
                total_reg <= total_reg + 1'b1;
            end
            if (cmd.do_delete) begin
                if (prev_reg == NIL)
                    head_valid_reg[bucket] <= 1'b1;
                in_use_reg[EW'(cur_reg)] <= 1'b0;
                if (total_reg != '0)
                    total_reg <= total_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            mode_reg <= req.mode;
            key_reg  <= req.key;
            val_reg  <= req.value;
            div_reg  <= div_next;
            quo_reg  <= req.key;
            rem_reg  <= '0;
            mcnt_reg <= '0;
            steps_reg <= '0;
            scan_reg <= '0;
        end
        if (cmd.mod_step) begin
            quo_reg  <= {quo_reg[30:0], 1'b0};
            rem_reg  <= (trial >= {1'b0, div_reg}) ? trial - {1'b0, div_reg} : trial;
            mcnt_reg <= mcnt_reg + 1'b1;
        end
        if (cmd.head_rd) begin
            cur_reg  <= head_valid_reg[bucket] ? head_mem[bucket] : NIL;
            headv_reg <= head_valid_reg[bucket] ? head_mem[bucket] : NIL;
            prev_reg <= NIL;
        end
        if (cmd.ent_rd) begin
            ekey_reg   <= key_mem[EW'(cur_reg)];
            evalue_reg <= val_mem[EW'(cur_reg)];
            enext_reg  <= next_mem[EW'(cur_reg)];
        end
        if (cmd.advance) begin
            prev_reg  <= cur_reg;
            cur_reg   <= enext_reg;
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.scan_step)
            scan_reg <= scan_reg + 1'b1;
        if (cmd.do_update)
            val_mem[EW'(cur_reg)] <= val_reg;
        if (cmd.do_insert) begin
            key_mem[EW'(scan_reg)]  <= key_reg;
            val_mem[EW'(scan_reg)]  <= val_reg;
            next_mem[EW'(scan_reg)] <= headv_reg;
            head_mem[bucket]        <= scan_reg;
        end
        if (cmd.do_delete) begin
            if (prev_reg == NIL)
                head_mem[bucket] <= enext_reg;
            else
                next_mem[EW'(prev_reg)] <= enext_reg;
        end
        if (cmd.set_rsp) begin
            rsp_reg.status      <= cmd.rsp_status;
            rsp_reg.found_value <= (cmd.rsp_status == chm_pkg::ST_FOUND) ? evalue_reg : 32'd0;
            rsp_reg.live_entries <= cmd.do_insert ? 9'(total_reg + 1'b1)
                                  : cmd.do_delete
                                    ? 9'(total_reg - ((total_reg != '0) ? 1'b1 : 1'b0))
                                    : 9'(total_reg);
        end
    end

    assign sts.mod_done   = (mcnt_reg == 6'd32);
    assign sts.cur_nil    = (cur_reg >= NIL);
    assign sts.key_match  = (ekey_reg == key_reg);
    assign sts.walk_limit = (steps_reg >= (PW+1)'(NUM_ENTRIES));
    assign sts.scan_done  = (scan_reg >= NIL) || !in_use_reg[EW'(scan_reg)];
    assign sts.scan_found = (scan_reg < NIL);
    assign sts.mode       = mode_reg;
    assign rsp            = rsp_reg;
endmodule

FILE: rtl/chm_ctrl.sv
// Controller state machine sequencing modulo, chain walk, free-slot scan and result.
// Depends on chm_pkg.
module chm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    input  chm_pkg::sts_t  sts,
    output chm_pkg::cmd_t  cmd
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MOD  = 8'b0000_0010,
        S_HEAD = 8'b0000_0100,
        S_TEST = 8'b0000_1000,
        S_READ = 8'b0001_0000,
        S_CMP  = 8'b0010_0000,
        S_SCAN = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (req_valid)
            begin
                cmd.load = 1'b1;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (sts.mod_done)
                begin
                    if (sts.mode == chm_pkg::MODE_NOP)
                    begin
                        cmd.set_rsp = 1'b1;
                        cmd.rsp_status = chm_pkg::ST_MISSING;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.head_rd = 1'b1;
                        state_next = S_TEST;
                    end
                end
                else
                    cmd.mod_step = 1'b1;
            end
            S_TEST:
            begin
                if (sts.cur_nil || sts.walk_limit)
                begin
                    if (sts.mode == chm_pkg::MODE_PUT)
                        state_next = S_SCAN;
                    else
                    begin
                        cmd.set_rsp = 1'b1;
                        cmd.rsp_status = chm_pkg::ST_MISSING;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (sts.key_match)
                begin
                    cmd.set_rsp = 1'b1;
                    state_next = S_OUT;
                    case (sts.mode)
                        chm_pkg::MODE_PUT:
                        begin
                            cmd.do_update = 1'b1;
                            cmd.rsp_status = chm_pkg::ST_UPDATED;
                        end
                        chm_pkg::MODE_GET: cmd.rsp_status = chm_pkg::ST_FOUND;
                        default:
                        begin
                            cmd.do_delete = 1'b1;
                            cmd.rsp_status = chm_pkg::ST_DELETED;
                        end
                    endcase
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next = S_TEST;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    cmd.set_rsp = 1'b1;
                    state_next = S_OUT;
                    if (sts.scan_found)
                    begin
                        cmd.do_insert = 1'b1;
                        cmd.rsp_status = chm_pkg::ST_INSERTED;
                    end
                    else
                        cmd.rsp_status = chm_pkg::ST_FULL;
                end
                else
                    cmd.scan_step = 1'b1;
            end
            S_OUT: if (rsp_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end
endmodule

FILE: rtl/chm_checker.sv
// Port-level checker for the chained hash map engine, bound to the top.
// Depends on chm_pkg.
module chm_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input chm_pkg::rsp_t rsp
);
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid)) else $error("request taken while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp)) else $error("result dropped");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status <= chm_pkg::ST_FULL) else $error("bad status");
    a_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != chm_pkg::ST_FOUND |-> rsp.found_value == 32'd0)
        else $error("value on miss");
endmodule

bind chained_hash_map_engine chm_checker u_chk (
    .clk, .rst_n, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp
);
